[rtl/rtt_pkg.sv]
// Package for the retransmit timer table.
// Table size, field widths, operation codes and configuration register indexes.
// Depends on nothing; used by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int TABLE_SLOTS = 8;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam int SEQ_W     = 32;
  localparam int TIME_W    = 32;
  localparam int RETRY_W   = 8;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int S_TDATA_W = SEQ_W + TIME_W;
  localparam int M_TDATA_W = SEQ_W;

  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = TIME_W'(1000);
  localparam logic [RETRY_W-1:0] RETRY_RESET   = RETRY_W'(3);

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER = 2'd0,
    FN_ACK      = 2'd1,
    FN_CHECK    = 2'd2
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

[rtl/retransmit_timer_table.sv]
// Retransmit timer table: top level.
// Uses rtt_pkg for sizes, operation codes and register indexes.
//
// Usage:
//   Input channel s_axis_*: tuser carries the operation (register, acknowledge,
//   check timeouts), tdata carries the sequence number and the current time.
//   Output channel m_axis_*: one item per input item; tuser is the status
//   (0 ok, 1 error), tdata the sequence number to resend on a good check.
//   Configuration channel cfg_*: index 0 timeout, index 1 retry limit; it is
//   always ready. The user must write it only while the table is idle; the
//   block does not enforce this. An item walks the slots one per cycle
//   through a single sequence compare and one 32-bit elapsed-time subtract
//   and compare. It stops at the slot that settles it or at the last slot;
//   the result is registered, then loaded into the output register once
//   that is free. One item is in work at a time; the next is taken once the
//   previous result sits in the output register.
//   Reset clears all valid bits and loads the register defaults; slot
//   contents are not cleared. When the receiver stalls, the result is held
//   in the output register and one more item may be scanned, then the table
//   waits until the output register frees up.
`timescale 1ns / 1ps

module retransmit_timer_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] sequence_req, [63:32] time_now
  input  logic [rtt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] func
  input  logic [rtt_pkg::FUNC_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] resend_sequence
  output logic [rtt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] result_status
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtt_pkg::CFG_DAT_W-1:0]     cfg_data
);

  rtt_pkg::state_t state;

  logic [rtt_pkg::TIME_W-1:0]  timeout_limit;
  logic [rtt_pkg::RETRY_W-1:0] retry_limit;

  logic [rtt_pkg::FUNC_W-1:0]  op_func;
  logic [rtt_pkg::SEQ_W-1:0]   op_seq;
  logic [rtt_pkg::TIME_W-1:0]  op_now;
  logic [rtt_pkg::SLOT_W-1:0]  idx;

  logic                        res_status;
  logic [rtt_pkg::SEQ_W-1:0]   res_seq;

  logic [rtt_pkg::TABLE_SLOTS-1:0] ent_valid;
  logic [rtt_pkg::SEQ_W-1:0]   ent_seq     [rtt_pkg::TABLE_SLOTS];
  logic [rtt_pkg::TIME_W-1:0]  ent_sent    [rtt_pkg::TABLE_SLOTS];
  logic [rtt_pkg::RETRY_W-1:0] ent_retries [rtt_pkg::TABLE_SLOTS];

  // current slot and the shared compare unit
  logic                        cur_valid;
  logic [rtt_pkg::SEQ_W-1:0]   cur_seq;
  logic [rtt_pkg::RETRY_W-1:0] cur_retries;
  logic [rtt_pkg::TIME_W-1:0]  elapsed;
  logic                        expired;
  logic                        last_slot;

  logic                        scan_done;
  logic                        scan_status;
  logic [rtt_pkg::SEQ_W-1:0]   scan_seq;
  logic                        wr_load;
  logic                        wr_bump;
  logic                        wr_clear;

  logic                        in_accept;
  logic                        out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == rtt_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign cur_valid   = ent_valid[idx];
  assign cur_seq     = ent_seq[idx];
  assign cur_retries = ent_retries[idx];
  assign elapsed     = op_now - ent_sent[idx];
  assign expired     = (elapsed >= timeout_limit);
  assign last_slot   = (idx == rtt_pkg::SLOT_W'(rtt_pkg::TABLE_SLOTS - 1));

  // per-slot decision of the sequencer
  always_comb begin
    scan_done   = 1'b0;
    scan_status = 1'b1;
    scan_seq    = '0;
    wr_load     = 1'b0;
    wr_bump     = 1'b0;
    wr_clear    = 1'b0;
    unique case (rtt_pkg::func_t'(op_func))
      rtt_pkg::FN_REGISTER: begin
        if (!cur_valid) begin
          wr_load     = 1'b1;
          scan_done   = 1'b1;
          scan_status = 1'b0;
        end else begin
          scan_done = last_slot;
        end
      end
      rtt_pkg::FN_ACK: begin
        if (cur_valid && (cur_seq == op_seq)) begin
          wr_clear    = 1'b1;
          scan_done   = 1'b1;
          scan_status = 1'b0;
        end else begin
          scan_done = last_slot;
        end
      end
      rtt_pkg::FN_CHECK: begin
        if (cur_valid && expired && (cur_retries >= retry_limit)) begin
          wr_clear  = 1'b1;    // out of retries: drop quietly, keep scanning
          scan_done = last_slot;
        end else if (cur_valid && expired) begin
          wr_bump     = 1'b1;
          scan_done   = 1'b1;
          scan_status = 1'b0;
          scan_seq    = cur_seq;
        end else begin
          scan_done = last_slot;
        end
      end
      default: begin
        scan_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= rtt_pkg::TIMEOUT_RESET;
      retry_limit   <= rtt_pkg::RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtt_pkg::CFG_TIMEOUT: timeout_limit <= cfg_data[rtt_pkg::TIME_W-1:0];
        rtt_pkg::CFG_RETRY:   retry_limit   <= cfg_data[rtt_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtt_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        rtt_pkg::ST_IDLE: begin
          if (in_accept) begin
            idx   <= '0;
            state <= rtt_pkg::ST_SCAN;
          end
        end
        rtt_pkg::ST_SCAN: begin
          if (scan_done) begin
            state <= rtt_pkg::ST_DONE;
          end else begin
            idx <= idx + rtt_pkg::SLOT_W'(1);
          end
        end
        rtt_pkg::ST_DONE: begin
          if (out_free) begin
            state <= rtt_pkg::ST_IDLE;
          end
        end
        default: state <= rtt_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_func <= s_axis_tuser;
      op_seq  <= s_axis_tdata[rtt_pkg::SEQ_W-1:0];
      op_now  <= s_axis_tdata[rtt_pkg::S_TDATA_W-1:rtt_pkg::SEQ_W];
    end
    if ((state == rtt_pkg::ST_SCAN) && scan_done) begin
      res_status <= scan_status;
      res_seq    <= scan_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (state == rtt_pkg::ST_SCAN) begin
      if (wr_load) begin
        ent_valid[idx] <= 1'b1;
      end else if (wr_clear) begin
        ent_valid[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rtt_pkg::ST_SCAN) begin
      if (wr_load) begin
        ent_seq[idx]     <= op_seq;
        ent_sent[idx]    <= op_now;
        ent_retries[idx] <= '0;
      end else if (wr_bump) begin
        ent_sent[idx]    <= op_now;
        ent_retries[idx] <= cur_retries + rtt_pkg::RETRY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == rtt_pkg::ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rtt_pkg::ST_DONE) && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= res_seq;
    end
  end

endmodule

[rtl/rtt_checker.sv]
// Port-level checker for the retransmit timer table, bound to the top level.
// Uses rtt_pkg for port widths.
`timescale 1ns / 1ps

module rtt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rtt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // a result does not rise straight after an accept; it follows the scan
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared without a scan cycle");

  // an error never carries a sequence number
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("error result with nonzero sequence");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind retransmit_timer_table rtt_checker u_rtt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_top.sv]
// Self-checking testbench for retransmit_timer_table: directed and random items with
// random idling on both stream sides, checked against a slot-level model of the table.
// Depends on rtt_pkg and retransmit_timer_table from the rtl folder.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [rtt_pkg::FUNC_W-1:0]    FN_UNUSED    = 2'd3;
  localparam logic [rtt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [rtt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int PHASES          = 8;
  localparam int HOLD_PHASE      = 4;
  localparam int PAUSE_PHASE     = 5;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 4000;

  typedef struct packed {
    logic                          status;
    logic [rtt_pkg::M_TDATA_W-1:0] resend_seq;
  } rtt_result_t;

  class rtt_scoreboard;
    logic [rtt_pkg::TIME_W-1:0]  timeout_lim;
    logic [rtt_pkg::RETRY_W-1:0] retry_max;
    bit                          slot_valid [rtt_pkg::TABLE_SLOTS];
    logic [rtt_pkg::SEQ_W-1:0]   slot_seq   [rtt_pkg::TABLE_SLOTS];
    logic [rtt_pkg::TIME_W-1:0]  slot_sent  [rtt_pkg::TABLE_SLOTS];
    logic [rtt_pkg::RETRY_W-1:0] slot_tries [rtt_pkg::TABLE_SLOTS];
    rtt_result_t                 outcomes_due [$];
    int                          errors;

    function new();
      timeout_lim = rtt_pkg::TIMEOUT_RESET;
      retry_max   = rtt_pkg::RETRY_RESET;
      errors      = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function void write_reg(logic [rtt_pkg::CFG_IDX_W-1:0] idx,
                            logic [rtt_pkg::CFG_DAT_W-1:0] data);
      if (idx == rtt_pkg::CFG_TIMEOUT) timeout_lim = data[rtt_pkg::TIME_W-1:0];
      else if (idx == rtt_pkg::CFG_RETRY) retry_max = data[rtt_pkg::RETRY_W-1:0];
    endfunction

    function rtt_result_t apply_op(logic [rtt_pkg::FUNC_W-1:0] func,
                                   logic [rtt_pkg::SEQ_W-1:0] seq,
                                   logic [rtt_pkg::TIME_W-1:0] now);
      rtt_result_t                r;
      logic [rtt_pkg::TIME_W-1:0] elapsed;
      bit                         done;
      int                         i;
      r.status     = 1'b1;
      r.resend_seq = '0;
      done         = 1'b0;
      case (func)
        rtt_pkg::FN_REGISTER: begin
          for (i = 0; i < rtt_pkg::TABLE_SLOTS; i++) begin
            if (!done && !slot_valid[i]) begin
              slot_valid[i] = 1'b1;
              slot_seq[i]   = seq;
              slot_sent[i]  = now;
              slot_tries[i] = '0;
              r.status      = 1'b0;
              done          = 1'b1;
            end
          end
        end
        rtt_pkg::FN_ACK: begin
          for (i = 0; i < rtt_pkg::TABLE_SLOTS; i++) begin
            if (!done && slot_valid[i] && slot_seq[i] == seq) begin
              slot_valid[i] = 1'b0;
              r.status      = 1'b0;
              done          = 1'b1;
            end
          end
        end
        rtt_pkg::FN_CHECK: begin
          for (i = 0; i < rtt_pkg::TABLE_SLOTS; i++) begin
            if (!done && slot_valid[i]) begin
              elapsed = now - slot_sent[i];
              if (elapsed >= timeout_lim) begin
                // out of retries: dropped quietly, scan goes on
                if (slot_tries[i] >= retry_max) begin
                  slot_valid[i] = 1'b0;
                end else begin
                  slot_tries[i] = slot_tries[i] + 1'b1;
                  slot_sent[i]  = now;
                  r.status      = 1'b0;
                  r.resend_seq  = slot_seq[i];
                  done          = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(logic [rtt_pkg::FUNC_W-1:0] func,
                            logic [rtt_pkg::SEQ_W-1:0] seq,
                            logic [rtt_pkg::TIME_W-1:0] now);
      outcomes_due.push_back(apply_op(func, seq, now));
    endfunction

    function void check_result(logic status, logic [rtt_pkg::M_TDATA_W-1:0] resend);
      rtt_result_t want;
      if (outcomes_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result item: status %0d resend %h", status, resend);
        return;
      end
      want = outcomes_due.pop_front();
      if (want.status !== status || want.resend_seq !== resend) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d resend %h, got status %0d resend %h",
                   want.status, want.resend_seq, status, resend);
      end
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    // sequence number of some live slot, to give acks a fair chance of a hit
    function logic [rtt_pkg::SEQ_W-1:0] live_seq();
      int picks [$];
      foreach (slot_valid[i]) if (slot_valid[i]) picks.push_back(i);
      if (picks.size() == 0) return $urandom;
      return slot_seq[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    // time at which some live slot just becomes due
    function logic [rtt_pkg::TIME_W-1:0] deadline();
      int picks [$];
      foreach (slot_valid[i]) if (slot_valid[i]) picks.push_back(i);
      if (picks.size() == 0) return $urandom;
      return slot_sent[picks[$urandom_range(0, picks.size() - 1)]] + timeout_lim;
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [rtt_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [rtt_pkg::FUNC_W-1:0]    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [rtt_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rtt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rtt_pkg::CFG_DAT_W-1:0] cfg_data;

  rtt_scoreboard              sb = new();
  bit                         tx_no_idle  = 1'b0;
  bit                         rx_no_idle  = 1'b0;
  bit                         rx_hold_req = 1'b0;
  logic [rtt_pkg::TIME_W-1:0] clock_ms;
  int                         idle_cycles = 0;

  retransmit_timer_table uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("retransmit_timer_table verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    forever begin
      if (rx_hold_req) begin
        stall       = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_no_idle ? 0 : $urandom_range(0, 13);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      // valid is unknown before the first reset edge
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  task automatic send_item(logic [rtt_pkg::FUNC_W-1:0] func,
                           logic [rtt_pkg::SEQ_W-1:0] seq,
                           logic [rtt_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {now, seq};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(func, seq, now);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_beat(logic [rtt_pkg::CFG_IDX_W-1:0] idx,
                          logic [rtt_pkg::CFG_DAT_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_limits(logic [rtt_pkg::TIME_W-1:0] tmo,
                              logic [rtt_pkg::RETRY_W-1:0] tries);
    logic [rtt_pkg::CFG_DAT_W-1:0] data;
    data          = $urandom;
    data[rtt_pkg::RETRY_W-1:0] = tries;
    cfg_valid <= 1'b1;
    cfg_beat(rtt_pkg::CFG_TIMEOUT, tmo);
    cfg_beat(rtt_pkg::CFG_RETRY, data);
    // spare index must leave both limits alone
    cfg_beat(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    logic [rtt_pkg::FUNC_W-1:0] func;
    logic [rtt_pkg::SEQ_W-1:0]  seq;
    logic [rtt_pkg::TIME_W-1:0] now;
    logic [rtt_pkg::TIME_W-1:0] step_max;
    int unsigned                roll;
    roll = $urandom_range(0, 99);
    if (roll < 38)      func = rtt_pkg::FN_REGISTER;
    else if (roll < 60) func = rtt_pkg::FN_ACK;
    else if (roll < 95) func = rtt_pkg::FN_CHECK;
    else                func = FN_UNUSED;
    roll = $urandom_range(0, 9);
    if (func == rtt_pkg::FN_ACK && roll < 7)           seq = sb.live_seq();
    else if (func == rtt_pkg::FN_REGISTER && roll < 2) seq = sb.live_seq();
    else if (roll == 9) seq = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else                seq = $urandom;
    step_max = (sb.timeout_lim > 32'h1000_0000) ? 32'h1000_0000 : sb.timeout_lim / 3 + 2;
    clock_ms = clock_ms + $urandom_range(0, step_max);
    roll = $urandom_range(0, 9);
    if (roll == 0)     now = $urandom;
    else if (roll < 3) now = sb.deadline() + $urandom_range(0, 2) - 1;
    else               now = clock_ms;
    send_item(func, seq, now);
  endtask

  initial begin
    int                          n;
    int                          ph;
    int                          count;
    logic [rtt_pkg::TIME_W-1:0]  tmo;
    logic [rtt_pkg::RETRY_W-1:0] tries;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= rtt_pkg::FN_REGISTER;
    cfg_valid     <= 1'b0;
    cfg_index     <= rtt_pkg::CFG_TIMEOUT;
    cfg_data      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset limits: 1000 ms, 3 retries
    send_item(rtt_pkg::FN_REGISTER, 32'h0, 32'hFFFF_FF00);
    send_item(rtt_pkg::FN_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rtt_pkg::FN_REGISTER, 32'h5A5A_5A5A, 32'h0);
    send_item(rtt_pkg::FN_REGISTER, 32'h5A5A_5A5A, 32'h1);
    for (n = 0; n < 4; n++) send_item(rtt_pkg::FN_REGISTER, 32'd10 + n, 32'd100);
    send_item(rtt_pkg::FN_REGISTER, 32'd99, 32'd200);      // table full
    send_item(rtt_pkg::FN_ACK, 32'd7, $urandom);           // no match
    send_item(rtt_pkg::FN_ACK, 32'h5A5A_5A5A, $urandom);   // duplicate: lower slot freed
    send_item(rtt_pkg::FN_REGISTER, 32'hA5A5_A5A5, 32'h8000_0000);
    send_item(rtt_pkg::FN_CHECK, $urandom, 32'h0000_02E8); // elapsed wraps, equals timeout
    send_item(rtt_pkg::FN_CHECK, $urandom, 32'h0000_02E8);
    send_item(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rtt_pkg::FN_CHECK, 32'h0, 32'h0000_02E8);    // nothing due
    // slot 0 runs out of retries and is dropped, the next due slot is resent
    for (n = 1; n <= 4; n++) send_item(rtt_pkg::FN_CHECK, $urandom, n * 32'h1_0000);
    drain();
    apply_limits('0, '0);
    send_item(rtt_pkg::FN_CHECK, $urandom, $urandom);      // zero retries: all dropped
    send_item(rtt_pkg::FN_ACK, 32'hA5A5_A5A5, $urandom);
    send_item(rtt_pkg::FN_REGISTER, 32'h1234_5678, 32'h0);
    send_item(rtt_pkg::FN_CHECK, $urandom, 32'h0);

    for (ph = 0; ph < PHASES; ph++) begin
      count = 250;
      case (ph)
        0: begin tmo = 32'd1000;     tries = 8'd3;   end
        1: begin tmo = '0;           tries = '0;     count = 100; end
        2: begin tmo = '1;           tries = '1;     end
        3: begin tmo = '0;           tries = '1;     count = 300; end
        4: begin tmo = 32'd1;        tries = 8'd1;   end
        5: begin tmo = 32'd50;       tries = 8'd2;   count = 300; end
        6: begin tmo = $urandom_range(0, 5000); tries = $urandom_range(0, 8); count = 300; end
        default: begin tmo = $urandom; tries = $urandom_range(0, 255); end
      endcase
      drain();
      apply_limits(tmo, tries);
      tx_no_idle = (ph == 1 || ph == HOLD_PHASE);
      rx_no_idle = (ph == 1 || ph == 7);
      clock_ms   = $urandom;
      for (n = 0; n < count; n++) begin
        if (ph == HOLD_PHASE && n == 40) rx_hold_req = 1'b1;
        if (ph == PAUSE_PHASE && n == 150) drain();
        send_random();
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (sb.errors == 0)
      $display("retransmit_timer_table verification clean");
    else
      $display("retransmit_timer_table verification failed");
    $finish;
  end

endmodule
